// File: design/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and the multiply-accumulate microprogram for the
// ray/triangle hit unit.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int INDEX_BITS_DEF = 24;

  localparam int ACC_W    = 104;  // exact width of det and the numerators
  localparam int PQ_W     = 68;   // storage width of the cross products
  localparam int OPA_W    = 33;   // edge / offset width
  localparam int HALF_W   = 34;   // split point of the wide multiplier operand
  localparam int MUL_W    = 35;   // signed multiplier input width
  localparam int QUO_W    = 42;   // signed quotient width
  localparam int QBITS    = 40;   // quotient bits produced by the divider
  localparam int NUM_PROD = 24;   // products in one triangle test
  localparam int NUM_STEP = 2 * NUM_PROD;
  localparam int FRAC_ONE = 65536;

  typedef enum logic [3:0] {
    A_D0, A_D1, A_D2, A_S0, A_S1, A_S2,
    A_E10, A_E11, A_E12, A_E20, A_E21, A_E22
  } a_sel_t;

  typedef enum logic [3:0] {
    B_E10, B_E11, B_E12, B_E20, B_E21, B_E22,
    B_P0, B_P1, B_P2, B_Q0, B_Q1, B_Q2
  } b_sel_t;

  typedef enum logic [3:0] {
    DS_NONE, DS_P0, DS_P1, DS_P2, DS_Q0, DS_Q1, DS_Q2,
    DS_DET, DS_NU, DS_NV, DS_NT
  } dest_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   neg;
    logic   first;
    logic   last;
    dest_t  dest;
  } mp_rec_t;

  typedef struct packed {
    logic  valid;
    logic  hi;
    logic  neg;
    logic  first;
    logic  last;
    dest_t dest;
  } mac_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_DETCHK, ST_DIV_GO, ST_DIV_WAIT, ST_EVAL, ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    DV_IDLE, DV_CHK, DV_RUN
  } div_state_t;

  typedef enum logic [1:0] {
    QS_U, QS_V, QS_T
  } quo_sel_t;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // One product of the test per entry: p = d x e2, q = s x e1, det = e1.p,
  // then s.p, d.q and e2.q.
  function automatic mp_rec_t mp_prod(input logic [4:0] n);
    mp_rec_t r;
    r = '{a: A_D0, b: B_E10, neg: 1'b0, first: 1'b0, last: 1'b0, dest: DS_NONE};
    unique case (n)
      5'd0:  r = '{A_D1,  B_E22, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd1:  r = '{A_D2,  B_E21, 1'b1, 1'b0, 1'b1, DS_P0};
      5'd2:  r = '{A_D2,  B_E20, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd3:  r = '{A_D0,  B_E22, 1'b1, 1'b0, 1'b1, DS_P1};
      5'd4:  r = '{A_D0,  B_E21, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd5:  r = '{A_D1,  B_E20, 1'b1, 1'b0, 1'b1, DS_P2};
      5'd6:  r = '{A_S1,  B_E12, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd7:  r = '{A_S2,  B_E11, 1'b1, 1'b0, 1'b1, DS_Q0};
      5'd8:  r = '{A_S2,  B_E10, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd9:  r = '{A_S0,  B_E12, 1'b1, 1'b0, 1'b1, DS_Q1};
      5'd10: r = '{A_S0,  B_E11, 1'b0, 1'b1, 1'b0, DS_NONE};
      5'd11: r = '{A_S1,  B_E10, 1'b1, 1'b0, 1'b1, DS_Q2};
      5'd12: r = '{A_E10, B_P0,  1'b0, 1'b1, 1'b0, DS_NONE};
      5'd13: r = '{A_E11, B_P1,  1'b0, 1'b0, 1'b0, DS_NONE};
      5'd14: r = '{A_E12, B_P2,  1'b0, 1'b0, 1'b1, DS_DET};
      5'd15: r = '{A_S0,  B_P0,  1'b0, 1'b1, 1'b0, DS_NONE};
      5'd16: r = '{A_S1,  B_P1,  1'b0, 1'b0, 1'b0, DS_NONE};
      5'd17: r = '{A_S2,  B_P2,  1'b0, 1'b0, 1'b1, DS_NU};
      5'd18: r = '{A_D0,  B_Q0,  1'b0, 1'b1, 1'b0, DS_NONE};
      5'd19: r = '{A_D1,  B_Q1,  1'b0, 1'b0, 1'b0, DS_NONE};
      5'd20: r = '{A_D2,  B_Q2,  1'b0, 1'b0, 1'b1, DS_NV};
      5'd21: r = '{A_E20, B_Q0,  1'b0, 1'b1, 1'b0, DS_NONE};
      5'd22: r = '{A_E21, B_Q1,  1'b0, 1'b0, 1'b0, DS_NONE};
      5'd23: r = '{A_E22, B_Q2,  1'b0, 1'b0, 1'b1, DS_NT};
      default: r = '{A_D0, B_E10, 1'b0, 1'b0, 1'b0, DS_NONE};
    endcase
    return r;
  endfunction

endpackage

// File: design/rtc_mac.sv
// ----------------------------------------------------------------------------
// rtc_mac
// Shared 35x35 multiplier with a wide accumulator; builds p, q, det and the
// three numerators one partial product per cycle.
// ----------------------------------------------------------------------------
module rtc_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic [2:0][rtc_pkg::OPA_W-1:0]        d_in,
  input  logic [2:0][rtc_pkg::OPA_W-1:0]        s_in,
  input  logic [2:0][rtc_pkg::OPA_W-1:0]        e1_in,
  input  logic [2:0][rtc_pkg::OPA_W-1:0]        e2_in,
  input  logic                                  issue,
  input  logic [5:0]                            step,
  output logic signed [rtc_pkg::ACC_W-1:0]      det,
  output logic signed [rtc_pkg::ACC_W-1:0]      num_u,
  output logic signed [rtc_pkg::ACC_W-1:0]      num_v,
  output logic signed [rtc_pkg::ACC_W-1:0]      num_t
);

  localparam int PROD_W = 2 * rtc_pkg::MUL_W;

  logic [2:0][rtc_pkg::OPA_W-1:0] d_r, s_r, e1_r, e2_r;
  logic [2:0][rtc_pkg::PQ_W-1:0]  p_r, q_r;
  logic signed [rtc_pkg::ACC_W-1:0] acc_r, acc_nxt, det_r, nu_r, nv_r, nt_r;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  rtc_pkg::mac_ctl_t              ctl_r, ctl_nxt;
  rtc_pkg::mp_rec_t               rec;
  logic [rtc_pkg::OPA_W-1:0]      a_val;
  logic [rtc_pkg::PQ_W-1:0]       b_val;
  logic signed [rtc_pkg::MUL_W-1:0] a_op, b_op;
  logic signed [rtc_pkg::ACC_W-1:0] term, base;

  assign rec = rtc_pkg::mp_prod(step[5:1]);

  always_comb begin
    unique case (rec.a)
      rtc_pkg::A_D0:  a_val = d_r[0];
      rtc_pkg::A_D1:  a_val = d_r[1];
      rtc_pkg::A_D2:  a_val = d_r[2];
      rtc_pkg::A_S0:  a_val = s_r[0];
      rtc_pkg::A_S1:  a_val = s_r[1];
      rtc_pkg::A_S2:  a_val = s_r[2];
      rtc_pkg::A_E10: a_val = e1_r[0];
      rtc_pkg::A_E11: a_val = e1_r[1];
      rtc_pkg::A_E12: a_val = e1_r[2];
      rtc_pkg::A_E20: a_val = e2_r[0];
      rtc_pkg::A_E21: a_val = e2_r[1];
      rtc_pkg::A_E22: a_val = e2_r[2];
      default:        a_val = '0;
    endcase
  end

  always_comb begin
    unique case (rec.b)
      rtc_pkg::B_E10: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e1_r[0][32]}}, e1_r[0]};
      rtc_pkg::B_E11: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e1_r[1][32]}}, e1_r[1]};
      rtc_pkg::B_E12: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e1_r[2][32]}}, e1_r[2]};
      rtc_pkg::B_E20: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e2_r[0][32]}}, e2_r[0]};
      rtc_pkg::B_E21: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e2_r[1][32]}}, e2_r[1]};
      rtc_pkg::B_E22: b_val = {{(rtc_pkg::PQ_W-rtc_pkg::OPA_W){e2_r[2][32]}}, e2_r[2]};
      rtc_pkg::B_P0:  b_val = p_r[0];
      rtc_pkg::B_P1:  b_val = p_r[1];
      rtc_pkg::B_P2:  b_val = p_r[2];
      rtc_pkg::B_Q0:  b_val = q_r[0];
      rtc_pkg::B_Q1:  b_val = q_r[1];
      rtc_pkg::B_Q2:  b_val = q_r[2];
      default:        b_val = '0;
    endcase
  end

  // Low half goes in unsigned, high half signed and weighted by 2^34.
  always_comb begin
    a_op = $signed({{(rtc_pkg::MUL_W-rtc_pkg::OPA_W){a_val[rtc_pkg::OPA_W-1]}}, a_val});
    if (step[0]) begin
      b_op = $signed({b_val[rtc_pkg::PQ_W-1], b_val[rtc_pkg::PQ_W-1:rtc_pkg::HALF_W]});
    end else begin
      b_op = $signed({1'b0, b_val[rtc_pkg::HALF_W-1:0]});
    end
    prod_nxt = a_op * b_op;
    ctl_nxt = '{valid: issue, hi: step[0], neg: rec.neg, first: rec.first,
                last: rec.last, dest: rec.dest};
  end

  always_comb begin
    term = $signed({{(rtc_pkg::ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
    if (ctl_r.hi) begin
      term = term <<< rtc_pkg::HALF_W;
    end
    base = (ctl_r.first && !ctl_r.hi) ? '0 : acc_r;
    acc_nxt = ctl_r.neg ? (base - term) : (base + term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      d_r  <= d_in;
      s_r  <= s_in;
      e1_r <= e1_in;
      e2_r <= e2_in;
    end
    prod_r <= prod_nxt;
    if (ctl_r.valid) begin
      acc_r <= acc_nxt;
      if (ctl_r.last && ctl_r.hi) begin
        unique case (ctl_r.dest)
          rtc_pkg::DS_P0:  p_r[0] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_P1:  p_r[1] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_P2:  p_r[2] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_Q0:  q_r[0] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_Q1:  q_r[1] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_Q2:  q_r[2] <= acc_nxt[rtc_pkg::PQ_W-1:0];
          rtc_pkg::DS_DET: det_r  <= acc_nxt;
          rtc_pkg::DS_NU:  nu_r   <= acc_nxt;
          rtc_pkg::DS_NV:  nv_r   <= acc_nxt;
          rtc_pkg::DS_NT:  nt_r   <= acc_nxt;
          default: ;
        endcase
      end
    end
  end

  assign det   = det_r;
  assign num_u = nu_r;
  assign num_v = nv_r;
  assign num_t = nt_r;

endmodule

// File: design/rtc_div.sv
// ----------------------------------------------------------------------------
// rtc_div
// Restoring divider: trunc(num * 65536 / den), one quotient bit per cycle,
// magnitude saturated at 2^40.
// ----------------------------------------------------------------------------
module rtc_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rtc_pkg::ACC_W-1:0]   num,
  input  logic signed [rtc_pkg::ACC_W-1:0]   den,
  output logic                               done,
  output logic signed [rtc_pkg::QUO_W-1:0]   quo
);

  localparam int W = rtc_pkg::ACC_W;
  localparam int QB = rtc_pkg::QBITS;

  rtc_pkg::div_state_t state_r, state_nxt;
  logic [5:0]    cnt_r;
  logic          neg_r, done_r;
  logic [W-1:0]  ad_r, rem_r, an, trial;
  logic [QB-1:0] nlow_r;
  logic [QB:0]   mag_r;
  logic          sat;

  assign an    = num[W-1] ? W'(-num) : W'(num);
  assign sat   = (rem_r >= ad_r);
  assign trial = {rem_r[W-2:0], nlow_r[QB-1]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtc_pkg::DV_IDLE: if (start) state_nxt = rtc_pkg::DV_CHK;
      rtc_pkg::DV_CHK:  state_nxt = sat ? rtc_pkg::DV_IDLE : rtc_pkg::DV_RUN;
      rtc_pkg::DV_RUN:  if (cnt_r == '0) state_nxt = rtc_pkg::DV_IDLE;
      default:          state_nxt = rtc_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    done = done_r;
    quo  = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtc_pkg::DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= ((state_r == rtc_pkg::DV_CHK) && sat) ||
                 ((state_r == rtc_pkg::DV_RUN) && (cnt_r == '0));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      rtc_pkg::DV_IDLE: begin
        if (start) begin
          neg_r  <= num[W-1] ^ den[W-1];
          ad_r   <= den[W-1] ? W'(-den) : W'(den);
          rem_r  <= an >> 24;
          nlow_r <= {an[23:0], 16'h0000};
          mag_r  <= '0;
          cnt_r  <= 6'(QB - 1);
        end
      end
      rtc_pkg::DV_CHK: begin
        if (sat) begin
          mag_r <= {1'b1, {QB{1'b0}}};
        end
      end
      rtc_pkg::DV_RUN: begin
        if (trial >= ad_r) begin
          rem_r <= trial - ad_r;
          mag_r <= {mag_r[QB-1:0], 1'b1};
        end else begin
          rem_r <= trial;
          mag_r <= {mag_r[QB-1:0], 1'b0};
        end
        nlow_r <= {nlow_r[QB-2:0], 1'b0};
        cnt_r  <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: design/ray_triangle_closest_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Moller-Trumbore ray/triangle test in Q16.16 with closest-hit or any-hit
// tracking against a stored ray.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  command, p0..p2 xyz, triangle_index
//  out_      output     out_valid/out_stall  this_hit, found, distance, u, v, tri
//  cfg_      input      cfg_wr_en            cfg_wr_data (closest_mode)
//
//  Load: result the cycle after accept. Triangle test: 48 partial products on
//  the shared 35x35 multiplier, drain and det check, three divisions (start,
//  range check, 40 quotient bits, done) and an update of the best hit; when
//  det is zero the divisions and the hit update are skipped, and a division
//  that saturates skips its quotient bits. in_stall holds until the result is
//  taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_unit #(
  parameter int INDEX_BITS = rtc_pkg::INDEX_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_command,
  input  logic signed [31:0]      in_p0_x,
  input  logic signed [31:0]      in_p0_y,
  input  logic signed [31:0]      in_p0_z,
  input  logic signed [31:0]      in_p1_x,
  input  logic signed [31:0]      in_p1_y,
  input  logic signed [31:0]      in_p1_z,
  input  logic signed [31:0]      in_p2_x,
  input  logic signed [31:0]      in_p2_y,
  input  logic signed [31:0]      in_p2_z,
  input  logic [INDEX_BITS-1:0]   in_triangle_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_this_hit,
  output logic                    out_found,
  output logic signed [31:0]      out_hit_distance,
  output logic [16:0]             out_hit_u,
  output logic [16:0]             out_hit_v,
  output logic [INDEX_BITS-1:0]   out_hit_triangle,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data
);

  localparam int QW = rtc_pkg::QUO_W;

  rtc_pkg::top_state_t state_r, state_nxt;
  rtc_pkg::quo_sel_t   qsel_r;
  logic [5:0]          step_r;
  logic                in_acc, out_acc;
  logic                mac_issue, div_start, div_done;
  logic                closest_r, found_r, this_hit_r;
  logic signed [31:0]  org_r [3];
  logic signed [31:0]  dir_r [3];
  logic signed [31:0]  near_r, far_r, best_t_r;
  logic [16:0]         best_u_r, best_v_r;
  logic [INDEX_BITS-1:0] best_idx_r, tri_r;
  logic [2:0][rtc_pkg::OPA_W-1:0] d_v, s_v, e1_v, e2_v;
  logic signed [rtc_pkg::ACC_W-1:0] det, num_u, num_v, num_t, div_num;
  logic signed [QW-1:0] quo, u_r, v_r, t_r, near_x, far_x;
  logic signed [QW:0]   uv_sum;
  logic                 hit;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    d_v[0]  = {dir_r[0][31], dir_r[0]};
    d_v[1]  = {dir_r[1][31], dir_r[1]};
    d_v[2]  = {dir_r[2][31], dir_r[2]};
    s_v[0]  = 33'(org_r[0]) - 33'(in_p0_x);
    s_v[1]  = 33'(org_r[1]) - 33'(in_p0_y);
    s_v[2]  = 33'(org_r[2]) - 33'(in_p0_z);
    e1_v[0] = 33'(in_p1_x) - 33'(in_p0_x);
    e1_v[1] = 33'(in_p1_y) - 33'(in_p0_y);
    e1_v[2] = 33'(in_p1_z) - 33'(in_p0_z);
    e2_v[0] = 33'(in_p2_x) - 33'(in_p0_x);
    e2_v[1] = 33'(in_p2_y) - 33'(in_p0_y);
    e2_v[2] = 33'(in_p2_z) - 33'(in_p0_z);
  end

  rtc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_acc && (in_command == rtc_pkg::CMD_TEST)),
    .d_in  (d_v),
    .s_in  (s_v),
    .e1_in (e1_v),
    .e2_in (e2_v),
    .issue (mac_issue),
    .step  (step_r),
    .det   (det),
    .num_u (num_u),
    .num_v (num_v),
    .num_t (num_t)
  );

  always_comb begin
    unique case (qsel_r)
      rtc_pkg::QS_U: div_num = num_u;
      rtc_pkg::QS_V: div_num = num_v;
      rtc_pkg::QS_T: div_num = num_t;
      default:       div_num = num_t;
    endcase
  end

  rtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    near_x = QW'(near_r);
    far_x  = QW'(far_r);
    uv_sum = (QW+1)'(u_r) + (QW+1)'(v_r);
    hit = (u_r >= 0) && (u_r <= rtc_pkg::FRAC_ONE) && (v_r >= 0) &&
          (uv_sum <= rtc_pkg::FRAC_ONE) && (t_r >= near_x) && (t_r <= far_x);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_command == rtc_pkg::CMD_TEST) ? rtc_pkg::ST_MAC : rtc_pkg::ST_OUT;
        end
      end
      rtc_pkg::ST_MAC: begin
        if (step_r == 6'(rtc_pkg::NUM_STEP - 1)) state_nxt = rtc_pkg::ST_DRAIN;
      end
      rtc_pkg::ST_DRAIN:  state_nxt = rtc_pkg::ST_DETCHK;
      rtc_pkg::ST_DETCHK: state_nxt = (det == '0) ? rtc_pkg::ST_OUT : rtc_pkg::ST_DIV_GO;
      rtc_pkg::ST_DIV_GO: state_nxt = rtc_pkg::ST_DIV_WAIT;
      rtc_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = (qsel_r == rtc_pkg::QS_T) ? rtc_pkg::ST_EVAL : rtc_pkg::ST_DIV_GO;
        end
      end
      rtc_pkg::ST_EVAL: state_nxt = rtc_pkg::ST_OUT;
      rtc_pkg::ST_OUT:  if (out_acc) state_nxt = rtc_pkg::ST_IDLE;
      default:          state_nxt = rtc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != rtc_pkg::ST_IDLE);
    out_valid = (state_r == rtc_pkg::ST_OUT);
    mac_issue = (state_r == rtc_pkg::ST_MAC);
    div_start = (state_r == rtc_pkg::ST_DIV_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rtc_pkg::ST_IDLE;
      closest_r  <= 1'b1;
      found_r    <= 1'b0;
      this_hit_r <= 1'b0;
      step_r     <= '0;
      qsel_r     <= rtc_pkg::QS_U;
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
      end
      near_r     <= '0;
      far_r      <= '0;
      best_t_r   <= '0;
      best_u_r   <= '0;
      best_v_r   <= '0;
      best_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        closest_r <= cfg_wr_data;
      end
      unique case (state_r)
        rtc_pkg::ST_IDLE: begin
          step_r <= '0;
          qsel_r <= rtc_pkg::QS_U;
          if (in_acc) begin
            this_hit_r <= 1'b0;
            tri_r      <= in_triangle_index;
            if (in_command == rtc_pkg::CMD_LOAD) begin
              org_r[0]   <= in_p0_x;
              org_r[1]   <= in_p0_y;
              org_r[2]   <= in_p0_z;
              dir_r[0]   <= in_p1_x;
              dir_r[1]   <= in_p1_y;
              dir_r[2]   <= in_p1_z;
              near_r     <= in_p2_x;
              far_r      <= in_p2_y;
              found_r    <= 1'b0;
              best_t_r   <= '0;
              best_u_r   <= '0;
              best_v_r   <= '0;
              best_idx_r <= '0;
            end
          end
        end
        rtc_pkg::ST_MAC: step_r <= step_r + 6'd1;
        rtc_pkg::ST_DIV_WAIT: begin
          if (div_done) begin
            unique case (qsel_r)
              rtc_pkg::QS_U: begin
                u_r    <= quo;
                qsel_r <= rtc_pkg::QS_V;
              end
              rtc_pkg::QS_V: begin
                v_r    <= quo;
                qsel_r <= rtc_pkg::QS_T;
              end
              default: t_r <= quo;
            endcase
          end
        end
        rtc_pkg::ST_EVAL: begin
          this_hit_r <= hit;
          if (hit) begin
            found_r <= 1'b1;
            if (closest_r || !found_r) begin
              best_t_r   <= t_r[31:0];
              best_u_r   <= u_r[16:0];
              best_v_r   <= v_r[16:0];
              best_idx_r <= tri_r;
            end
            if (closest_r) begin
              far_r <= t_r[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_this_hit     = this_hit_r;
  assign out_found        = found_r;
  assign out_hit_distance = best_t_r;
  assign out_hit_u        = best_u_r;
  assign out_hit_v        = best_v_r;
  assign out_hit_triangle = best_idx_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_load_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_command == rtc_pkg::CMD_LOAD)) |=> !out_found && !out_this_hit)
    else $error("ray load left a stale hit");

  a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == rtc_pkg::ST_DIV_WAIT))
    else $error("divider finished outside the wait state");

  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> !out_valid)
    else $error("result shown twice");
`endif

endmodule
